// ----- rtl/bdsl_pkg.sv -----
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types, codes and sizes for the bounded depth-sorted list.
// ----------------------------------------------------------------------------
`default_nettype none

package bdsl_pkg;

  localparam int CAPACITY = 128;

  localparam int KIND_W  = 2;
  localparam int DEPTH_W = 31;
  localparam int TAG_W   = 16;
  localparam int RANK_W  = 7;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 8;

  // Entry count runs 0..CAPACITY.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

  // Read selection: only ranks a 7-bit rank can name are readable.
  localparam int RANK_SPAN = 1 << RANK_W;
  localparam int READ_N    = (CAPACITY < RANK_SPAN) ? CAPACITY : RANK_SPAN;
  localparam int LANE_W    = 3;
  localparam int GRP_SZ    = 1 << LANE_W;
  localparam int GRP_N     = (READ_N + GRP_SZ - 1) / GRP_SZ;
  localparam int GRP_SEL_W = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int GRP_N2    = 1 << GRP_SEL_W;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EVICTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DEPTH_W-1:0] depth;
    logic [TAG_W-1:0]   tag;
    logic [RANK_W-1:0]  rank;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DEPTH_W-1:0] out_depth;
    logic [TAG_W-1:0]   out_tag;
    logic [FILL_W-1:0]  fill;
  } out_item_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   grow;   // insert into a store that has room
    logic   evict;  // insert into a full store, farthest entry drops out
    entry_t key;    // entry being inserted
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/bdsl_cell.sv -----
// ----------------------------------------------------------------------------
// bdsl_cell
// One slot of the sorted chain: compares, then keeps, shifts or loads.
// ----------------------------------------------------------------------------
`default_nettype none

module bdsl_cell (
  input  wire                  clk,
  input  bdsl_pkg::cell_ctrl_t ctrl,
  input  wire                  valid,
  input  bdsl_pkg::entry_t     prv_ent,
  input  wire                  prv_gt,
  input  bdsl_pkg::entry_t     nxt_ent,
  input  wire                  nxt_gt,
  output bdsl_pkg::entry_t     ent,
  output logic                 gt
);

  bdsl_pkg::entry_t ent_r;
  bdsl_pkg::entry_t ent_nxt;

  // Strictly farther than the new key: stays ahead of it.
  assign gt  = valid && (ent_r.depth > ctrl.key.depth);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.grow) begin
      // Move toward the near end behind the insertion point.
      if (gt) begin
        ent_nxt = ent_r;
      end else if (prv_gt) begin
        ent_nxt = ctrl.key;
      end else begin
        ent_nxt = prv_ent;
      end
    end else if (ctrl.evict) begin
      // Move toward rank 0 ahead of the insertion point.
      if (nxt_gt) begin
        ent_nxt = nxt_ent;
      end else if (gt) begin
        ent_nxt = ctrl.key;
      end else begin
        ent_nxt = ent_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/bdsl_rdsel.sv -----
// ----------------------------------------------------------------------------
// bdsl_rdsel
// Two-step rank select: registered groups of eight, then group pick.
// ----------------------------------------------------------------------------
`default_nettype none

module bdsl_rdsel (
  input  wire                            clk,
  input  wire                            en,
  input  bdsl_pkg::entry_t               ents [bdsl_pkg::READ_N],
  input  wire [bdsl_pkg::RANK_W-1:0]     rank,
  output bdsl_pkg::entry_t               rd_ent
);

  bdsl_pkg::entry_t                   grp_r   [bdsl_pkg::GRP_N2];
  bdsl_pkg::entry_t                   grp_nxt [bdsl_pkg::GRP_N2];
  logic [bdsl_pkg::GRP_SEL_W-1:0]     sel_r;

  genvar g, k;
  generate
    for (g = 0; g < bdsl_pkg::GRP_N2; g++) begin : g_grp
      bdsl_pkg::entry_t lane [bdsl_pkg::GRP_SZ];
      for (k = 0; k < bdsl_pkg::GRP_SZ; k++) begin : g_lane
        if (g * bdsl_pkg::GRP_SZ + k < bdsl_pkg::READ_N) begin : g_real
          assign lane[k] = ents[g * bdsl_pkg::GRP_SZ + k];
        end else begin : g_pad
          assign lane[k] = '0;
        end
      end
      assign grp_nxt[g] = lane[rank[bdsl_pkg::LANE_W-1:0]];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
      sel_r <= rank[bdsl_pkg::GRP_SEL_W+bdsl_pkg::LANE_W-1:bdsl_pkg::LANE_W];
    end
  end

  assign rd_ent = grp_r[sel_r];

endmodule

`default_nettype wire

// ----- rtl/bounded_depth_sorted_list.sv -----
// ----------------------------------------------------------------------------
// bounded_depth_sorted_list
// Keeps up to CAPACITY (depth, tag) entries sorted farthest first.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                          Beat
//  -------  -----------------------------  -----------------------------------
//  input    in_valid  in_ready  in_data    one command: clear, insert or read
//  result   out_valid out_ready out_data   one result per command
//
//  Inserts compare every cell's depth against the new key in parallel; the
//  chain shifts on the accepting edge unless the insert is dropped. Clear
//  resets the count. Reads pass through the registered two-level selector.
//  One command is in flight at a time; in_ready drops while a read is in the
//  selector or while a result beat is held by out_ready low.
//  rst_n (synchronous) empties the store; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_depth_sorted_list (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bdsl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output bdsl_pkg::out_item_t out_data
);

  localparam int CAP = bdsl_pkg::CAPACITY;

  // Control state
  logic [bdsl_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       rd_busy_r, rd_busy_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Read in flight and result register (payload, no reset)
  logic                        rd_hit_r;
  logic [bdsl_pkg::FILL_W-1:0] rd_fill_r;
  bdsl_pkg::out_item_t         out_r, out_nxt;

  // Chain wiring
  bdsl_pkg::entry_t     cell_ent [CAP];
  logic                 cell_gt  [CAP];
  bdsl_pkg::entry_t     rd_ents  [bdsl_pkg::READ_N];
  bdsl_pkg::entry_t     rd_ent;
  bdsl_pkg::cell_ctrl_t ctrl;

  logic in_acc, out_free, is_read, is_ins, is_clr, full, rd_hit;
  logic ld_direct, ld_rd;
  logic [bdsl_pkg::STAT_W-1:0] dir_status;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !rd_busy_r && out_free;
  assign in_acc   = in_valid && in_ready;

  assign is_clr  = (in_data.kind == bdsl_pkg::KIND_CLEAR);
  assign is_ins  = (in_data.kind == bdsl_pkg::KIND_INSERT);
  assign is_read = (in_data.kind == bdsl_pkg::KIND_READ);
  assign full    = (count_r == bdsl_pkg::CNT_W'(CAP));
  assign rd_hit  = (bdsl_pkg::CMP_W'(in_data.rank) < bdsl_pkg::CMP_W'(count_r));

  // Broadcast the insert to the chain; a full store only takes the new
  // entry when rank 0 is strictly farther than it.
  assign ctrl.key.depth = in_data.depth;
  assign ctrl.key.tag   = in_data.tag;
  assign ctrl.grow      = in_acc && is_ins && !full;
  assign ctrl.evict     = in_acc && is_ins && full && cell_gt[0];

  genvar i;
  generate
    for (i = 0; i < CAP; i++) begin : g_cell
      bdsl_pkg::entry_t prv_ent, nxt_ent;
      logic             prv_gt, nxt_gt;
      if (i == 0) begin : g_head
        assign prv_ent = ctrl.key;
        assign prv_gt  = 1'b1;
      end else begin : g_mid_p
        assign prv_ent = cell_ent[i-1];
        assign prv_gt  = cell_gt[i-1];
      end
      if (i == CAP - 1) begin : g_tail
        assign nxt_ent = ctrl.key;
        assign nxt_gt  = 1'b0;
      end else begin : g_mid_n
        assign nxt_ent = cell_ent[i+1];
        assign nxt_gt  = cell_gt[i+1];
      end
      bdsl_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .valid   (count_r > bdsl_pkg::CNT_W'(i)),
        .prv_ent (prv_ent),
        .prv_gt  (prv_gt),
        .nxt_ent (nxt_ent),
        .nxt_gt  (nxt_gt),
        .ent     (cell_ent[i]),
        .gt      (cell_gt[i])
      );
    end
    for (i = 0; i < bdsl_pkg::READ_N; i++) begin : g_rd
      assign rd_ents[i] = cell_ent[i];
    end
  endgenerate

  bdsl_rdsel u_rdsel (
    .clk    (clk),
    .en     (in_acc && is_read),
    .ents   (rd_ents),
    .rank   (in_data.rank),
    .rd_ent (rd_ent)
  );

  // Count update and status of the commands other than read.
  always_comb begin
    count_nxt  = count_r;
    dir_status = bdsl_pkg::ST_DONE;
    if (in_acc) begin
      if (is_clr) begin
        count_nxt = '0;
      end else if (is_ins) begin
        if (!full) begin
          count_nxt = count_r + bdsl_pkg::CNT_W'(1);
        end else if (cell_gt[0]) begin
          dir_status = bdsl_pkg::ST_EVICTED;
        end else begin
          dir_status = bdsl_pkg::ST_DROPPED;
        end
      end
    end
  end

  assign ld_direct = in_acc && !is_read;
  assign ld_rd     = rd_busy_r && out_free;

  always_comb begin
    out_nxt = out_r;
    if (ld_direct) begin
      out_nxt.status    = dir_status;
      out_nxt.out_depth = '0;
      out_nxt.out_tag   = '0;
      out_nxt.fill      = bdsl_pkg::FILL_W'(count_nxt);
    end else if (ld_rd) begin
      out_nxt.status    = rd_hit_r ? bdsl_pkg::ST_DONE : bdsl_pkg::ST_EMPTY;
      out_nxt.out_depth = rd_hit_r ? rd_ent.depth : '0;
      out_nxt.out_tag   = rd_hit_r ? rd_ent.tag : '0;
      out_nxt.fill      = rd_fill_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_direct || ld_rd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    rd_busy_nxt = rd_busy_r;
    if (in_acc && is_read) begin
      rd_busy_nxt = 1'b1;
    end else if (ld_rd) begin
      rd_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_busy_r   <= rd_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold read status and fill alongside the selector stage.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_acc && is_read) begin
      rd_hit_r  <= rd_hit;
      rd_fill_r <= bdsl_pkg::FILL_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bdsl_pkg::CNT_W'(CAP))
    else $error("entry count above capacity");

  a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    rd_busy_r |-> !in_ready)
    else $error("input taken while a read is in flight");

  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_read) |=> rd_busy_r)
    else $error("read accepted without entering the selector");

  a_full_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_ins && full) |=> (count_r == $past(count_r)))
    else $error("insert into full store changed the count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == bdsl_pkg::ST_EMPTY)) |->
      ((out_r.out_depth == '0) && (out_r.out_tag == '0)))
    else $error("empty read result carries data");
`endif

endmodule

`default_nettype wire

// ----- verif/bounded_depth_sorted_list_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_depth_sorted_list_tb
// Self-checking bench for the bounded depth-sorted list.
//
// A local copy of the sorted store predicts every result beat from the
// commands the block accepts. Directed commands cover the corner cases. A
// fill phase drives the store to capacity and forces evictions and drops.
// Random episodes follow, then a long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------

module bounded_depth_sorted_list_tb;

  // The package names only three kinds; the fourth code must be a no-op.
  localparam logic [bdsl_pkg::KIND_W-1:0]  KIND_UNUSED = 2'd3;
  localparam logic [bdsl_pkg::DEPTH_W-1:0] DEPTH_MAX   = '1;
  localparam logic [bdsl_pkg::TAG_W-1:0]   TAG_MAX     = '1;
  localparam logic [bdsl_pkg::RANK_W-1:0]  RANK_MAX    = '1;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_COMMANDS = 500;
  localparam int FILL_INSERTS    = 140;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  bdsl_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  bdsl_pkg::out_item_t out_data;

  // Local copy of the store: entries farthest first, plus the fill count.
  bdsl_pkg::entry_t    sorted_entries [bdsl_pkg::CAPACITY];
  int                  entry_total;
  bdsl_pkg::out_item_t pending_results [$];

  int        status_seen [4];
  int        peak_fill;
  int        commands_sent;
  int        fail_count;
  int        cycle_count;

  // Sender burst shaping and receiver stall pattern.
  int        burst_left;
  bit        sender_idles;
  rx_mode_t  rx_mode;
  int        rx_phase;
  int        hold_cycles_req;
  int        hold_left;

  bounded_depth_sorted_list DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted command to the local store and return the
  // result beat it must produce.
  // --------------------------------------------------------------------------
  function automatic bdsl_pkg::out_item_t apply_command(input bdsl_pkg::in_item_t cmd);
    bdsl_pkg::out_item_t res;
    int                  pos;
    int                  i;
    res = '0;
    case (cmd.kind)
      bdsl_pkg::KIND_CLEAR: begin
        entry_total = 0;
      end
      bdsl_pkg::KIND_INSERT: begin
        // Land ahead of every entry that is not strictly farther.
        pos = 0;
        while (pos < entry_total && sorted_entries[pos].depth > cmd.depth) pos++;
        if (entry_total >= bdsl_pkg::CAPACITY) begin
          if (pos == 0) begin
            // At least as far as the farthest entry: drop the newcomer.
            res.status = bdsl_pkg::ST_DROPPED;
          end else begin
            // Shift the farther entries toward rank 0; old rank 0 falls out.
            for (i = 0; i + 1 < pos; i++) sorted_entries[i] = sorted_entries[i + 1];
            sorted_entries[pos - 1] = '{depth: cmd.depth, tag: cmd.tag};
            res.status = bdsl_pkg::ST_EVICTED;
          end
        end else begin
          for (i = entry_total; i > pos; i--) sorted_entries[i] = sorted_entries[i - 1];
          sorted_entries[pos] = '{depth: cmd.depth, tag: cmd.tag};
          entry_total++;
        end
      end
      bdsl_pkg::KIND_READ: begin
        if (cmd.rank < entry_total) begin
          res.out_depth = sorted_entries[cmd.rank].depth;
          res.out_tag   = sorted_entries[cmd.rank].tag;
        end else begin
          res.status = bdsl_pkg::ST_EMPTY;
        end
      end
      default: ;  // unused kind leaves the store alone
    endcase
    res.fill = bdsl_pkg::FILL_W'(entry_total);
    if (entry_total > peak_fill) peak_fill = entry_total;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Command builders
  // --------------------------------------------------------------------------
  function automatic bdsl_pkg::in_item_t make_cmd(
      input logic [bdsl_pkg::KIND_W-1:0]  kind,
      input logic [bdsl_pkg::DEPTH_W-1:0] depth,
      input logic [bdsl_pkg::TAG_W-1:0]   tag,
      input logic [bdsl_pkg::RANK_W-1:0]  rank);
    bdsl_pkg::in_item_t c;
    c.kind  = kind;
    c.depth = depth;
    c.tag   = tag;
    c.rank  = rank;
    return c;
  endfunction

  // Mix extremes, a narrow band that forces ties, and the full 31-bit range.
  function automatic logic [bdsl_pkg::DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DEPTH_MAX;
      2, 3:    return bdsl_pkg::DEPTH_W'($urandom_range(0, 15));
      default: return bdsl_pkg::DEPTH_W'($urandom());
    endcase
  endfunction

  // Half uniform over the whole field, half aimed at the occupied ranks.
  function automatic logic [bdsl_pkg::RANK_W-1:0] pick_rank();
    int hi;
    hi = (entry_total > int'(RANK_MAX)) ? int'(RANK_MAX) : entry_total;
    if ($urandom_range(0, 1) == 0)
      return bdsl_pkg::RANK_W'($urandom_range(0, int'(RANK_MAX)));
    return bdsl_pkg::RANK_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [bdsl_pkg::KIND_W-1:0] pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return bdsl_pkg::KIND_INSERT;
    if (roll < 94) return bdsl_pkg::KIND_READ;
    if (roll < 97) return KIND_UNUSED;
    return bdsl_pkg::KIND_CLEAR;
  endfunction

  function automatic bdsl_pkg::in_item_t random_cmd(
      input logic [bdsl_pkg::KIND_W-1:0] kind);
    return make_cmd(kind, pick_depth(), bdsl_pkg::TAG_W'($urandom()), pick_rank());
  endfunction

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after the
  // beat is taken. Valid stays high across back-to-back beats; between bursts
  // of an idling sender, drop it for a random gap and scramble the payload.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input bdsl_pkg::in_item_t cmd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_data  <= random_cmd(bdsl_pkg::KIND_W'($urandom_range(0, 3)));
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    commands_sent++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: a hold-off request wins; otherwise stall per the current mode.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles_req != 0) begin
      hold_left       = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 99) >= 35);
        default: begin
          rx_phase++;
          out_ready <= ((rx_phase % 7) < 4);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted command beat, then check every result
  // beat against the oldest prediction. Predict first so the order holds even
  // if a result could leave on the same edge.
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bdsl_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) pending_results.push_back(apply_command(in_data));
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("out_depth", 32'(want.out_depth), 32'(out_data.out_depth));
          check_field("out_tag", 32'(want.out_tag), 32'(out_data.out_tag));
          check_field("fill", 32'(want.fill), 32'(out_data.fill));
        end
      end
    end
  end

  // Watchdog: bail out if the run stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout with %0d results still expected", pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases: empty reads, the unused kind, depth and tag extremes, ties
  // (newest first), reads past the fill, and a clear followed by reuse.
  task automatic test_directed();
    int r;
    sender_idles = 1'b0;
    rx_mode      = RX_PATTERN;
    send_cmd(make_cmd(bdsl_pkg::KIND_READ, '0, '0, '0));
    send_cmd(make_cmd(KIND_UNUSED, DEPTH_MAX, TAG_MAX, RANK_MAX));
    send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, DEPTH_MAX, TAG_MAX, '0));
    send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, '0, '0, RANK_MAX));
    send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, 31'd5, 16'd1, '0));
    send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, 31'd5, 16'd2, '0));
    send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, DEPTH_MAX, 16'h1234, '0));
    for (r = 0; r < 6; r++)
      send_cmd(make_cmd(bdsl_pkg::KIND_READ, '0, '0, bdsl_pkg::RANK_W'(r)));
    send_cmd(make_cmd(bdsl_pkg::KIND_READ, DEPTH_MAX, TAG_MAX, RANK_MAX));
    send_cmd(make_cmd(bdsl_pkg::KIND_CLEAR, DEPTH_MAX, TAG_MAX, RANK_MAX));
    send_cmd(make_cmd(bdsl_pkg::KIND_READ, '0, '0, '0));
    send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, 31'h2AAAAAAA, 16'h5555, 7'h55));
    send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, 31'h55555555, 16'hAAAA, 7'h2A));
    send_cmd(make_cmd(bdsl_pkg::KIND_READ, '0, '0, '0));
    send_cmd(make_cmd(bdsl_pkg::KIND_READ, '0, '0, 7'd1));
  endtask

  // Fill past capacity, read every rank, then push dropped and evicting
  // inserts into the full store.
  task automatic test_fill_and_evict();
    int n;
    sender_idles = 1'b1;
    rx_mode      = RX_RANDOM;
    send_cmd(random_cmd(bdsl_pkg::KIND_CLEAR));
    for (n = 0; n < FILL_INSERTS; n++) send_cmd(random_cmd(bdsl_pkg::KIND_INSERT));
    for (n = 0; n <= int'(RANK_MAX); n++)
      send_cmd(make_cmd(bdsl_pkg::KIND_READ, pick_depth(), bdsl_pkg::TAG_W'($urandom()),
                        bdsl_pkg::RANK_W'(n)));
    // The farthest entry can be no farther than the maximum: always dropped.
    for (n = 0; n < 20; n++)
      send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, DEPTH_MAX, bdsl_pkg::TAG_W'($urandom()),
                        pick_rank()));
    for (n = 0; n < 20; n++)
      send_cmd(make_cmd(bdsl_pkg::KIND_INSERT, '0, bdsl_pkg::TAG_W'($urandom()),
                        pick_rank()));
    for (n = 0; n < 4; n++) begin
      send_cmd(make_cmd(bdsl_pkg::KIND_READ, '0, '0, bdsl_pkg::RANK_W'(n)));
      send_cmd(make_cmd(bdsl_pkg::KIND_READ, '0, '0, RANK_MAX - bdsl_pkg::RANK_W'(n)));
    end
  endtask

  // Episodes start from a clear and run a random length, at times enough to
  // fill the store; each picks its own sender and receiver idling.
  task automatic test_random_episodes();
    int budget;
    int len;
    int n;
    budget = RANDOM_COMMANDS;
    while (budget > 0) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      len          = $urandom_range(10, 250);
      if (len > budget) len = budget;
      send_cmd(random_cmd(bdsl_pkg::KIND_CLEAR));
      for (n = 1; n < len; n++) send_cmd(random_cmd(pick_kind()));
      budget -= len;
    end
  endtask

  // Hold the receiver off for a long stretch while commands keep coming, so
  // the block has to stall its input.
  task automatic test_backpressure();
    int n;
    sender_idles    = 1'b0;
    rx_mode         = RX_ALWAYS;
    hold_cycles_req = HOLD_OFF_CYCLES;
    for (n = 0; n < 60; n++) send_cmd(random_cmd(pick_kind()));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    entry_total     = 0;
    peak_fill       = 0;
    commands_sent   = 0;
    fail_count      = 0;
    cycle_count     = 0;
    burst_left      = 0;
    sender_idles    = 1'b0;
    rx_mode         = RX_ALWAYS;
    rx_phase        = 0;
    hold_cycles_req = 0;
    hold_left       = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Hold reset, then release it away from the sampling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_fill_and_evict();
    test_random_episodes();
    test_backpressure();

    // Stop offering, drain every expected beat, then idle a little longer so
    // any stray beat still shows up as unexpected.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    rx_mode = RX_ALWAYS;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands: %0d done, %0d evicted, %0d dropped, %0d empty reads",
             commands_sent, status_seen[bdsl_pkg::ST_DONE],
             status_seen[bdsl_pkg::ST_EVICTED], status_seen[bdsl_pkg::ST_DROPPED],
             status_seen[bdsl_pkg::ST_EMPTY]);
    $display("peak fill %0d of %0d, %0d cycles, %0d mismatches",
             peak_fill, bdsl_pkg::CAPACITY, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
